// ===== design/tlpt_pkg.sv =====
`timescale 1ns / 1ps

package tlpt_pkg;

	localparam int DIR_ENTRIES   = 1024;
	localparam int TABLE_ENTRIES = 1024;
	localparam int TABLE_SLOTS   = 8;

	localparam int DIR_IDX_W  = $clog2(DIR_ENTRIES);
	localparam int TBL_IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int TBL_ADDR_W = SLOT_W + TBL_IDX_W;
	localparam int TBL_DEPTH  = TABLE_SLOTS * TABLE_ENTRIES;
	localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
	localparam int CFG_W      = 4;
	localparam int LIM_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	localparam logic [CFG_W-1:0] LIMIT_RESET = 4'd8;

	localparam logic [31:0] FRAME_MASK   = ~32'hFFF;
	localparam logic [11:0] FLAG_PRESENT = 12'h001;

	localparam logic [1:0] OP_MAP   = 2'd0;
	localparam logic [1:0] OP_UNMAP = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic              present;
		logic [11:0]       flags;
		logic [SLOT_W-1:0] slot;
	} dir_entry_t;

	typedef struct packed {
		logic                 en;
		logic                 we;
		logic [DIR_IDX_W-1:0] addr;
		dir_entry_t           wdata;
	} dir_req_t;

	typedef struct packed {
		logic                  en;
		logic                  we;
		logic [TBL_ADDR_W-1:0] addr;
		logic [31:0]           wdata;
	} tbl_req_t;

endpackage

// ===== design/tlpt_if.sv =====
`timescale 1ns / 1ps

interface tlpt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] virt_addr;
	logic [31:0] phys_addr;
	logic [11:0] entry_flags;

	modport source (output valid, operation, virt_addr, phys_addr, entry_flags, input ready);
	modport sink   (input valid, operation, virt_addr, phys_addr, entry_flags, output ready);
endinterface

interface tlpt_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic        is_mapped;
	logic [31:0] phys_result;

	modport source (output valid, status, is_mapped, phys_result, input ready);
	modport sink   (input valid, status, is_mapped, phys_result, output ready);
endinterface

interface tlpt_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] table_slot_limit;

	modport source (output valid, table_slot_limit, input ready);
	modport sink   (input valid, table_slot_limit, output ready);
endinterface

// ===== design/two_level_page_table_engine.sv =====
`timescale 1ns / 1ps
// Each item runs a directory read (ST_DIR), a table read (ST_TRD) for a query to a present entry,
// and ST_RESP, which registers the result. A map that allocates a new table also runs a 1024-entry
// clear sweep (ST_CLR) and the entry write (ST_WR). ST_RESP waits while the previous result
// is still not taken by rsp.ready; items are processed one at a time.
// Reset: a directory clear pass over all 1024 entries runs with req.ready low; config writes are taken.

module two_level_page_table_engine (
	input  logic       clk,
	input  logic       arst_n,
	tlpt_req_if.sink   req,
	tlpt_rsp_if.source rsp,
	tlpt_cfg_if.sink   cfg
);
	import tlpt_pkg::*;

	dir_req_t    dir_req;
	dir_entry_t  dir_rdata;
	tbl_req_t    tbl_req;
	logic [31:0] tbl_rdata;

	tlpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg       (cfg),
		.dir_req   (dir_req),
		.dir_rdata (dir_rdata),
		.tbl_req   (tbl_req),
		.tbl_rdata (tbl_rdata)
	);

	tlpt_dir_ram u_dir_ram (
		.clk   (clk),
		.req   (dir_req),
		.rdata (dir_rdata)
	);

	tlpt_tbl_ram u_tbl_ram (
		.clk   (clk),
		.req   (tbl_req),
		.rdata (tbl_rdata)
	);

	// directory writes only happen while no item can be taken
	a_dir_wr_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(dir_req.en && dir_req.we) |-> !req.ready)
		else $error("directory write while accepting an item");

	// table accesses stay inside the slot pool
	a_tbl_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_req.en |-> ({1'b0, tbl_req.addr[TBL_ADDR_W-1 -: SLOT_W]}
			< (SLOT_W + 1)'(TABLE_SLOTS)))
		else $error("table access beyond slot pool");

	// a failed map reports nothing mapped
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status) |-> (!rsp.is_mapped && rsp.phys_result == 32'd0))
		else $error("failed map carries a translation");

	// no table access in a cycle that accepts an item
	a_tbl_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> !tbl_req.en)
		else $error("table access while accepting an item");

endmodule

// ===== design/tlpt_dir_ram.sv =====
`timescale 1ns / 1ps

module tlpt_dir_ram (
	input  logic                clk,
	input  tlpt_pkg::dir_req_t   req,
	output tlpt_pkg::dir_entry_t rdata
);
	import tlpt_pkg::*;

	dir_entry_t mem [DIR_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata <= mem[req.addr];
			end
		end
	end

endmodule

// ===== design/tlpt_tbl_ram.sv =====
`timescale 1ns / 1ps

module tlpt_tbl_ram (
	input  logic               clk,
	input  tlpt_pkg::tbl_req_t req,
	output logic [31:0]        rdata
);
	import tlpt_pkg::*;

	logic [31:0] mem [TBL_DEPTH];

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata <= mem[req.addr];
			end
		end
	end

endmodule

// ===== design/tlpt_ctrl.sv =====
`timescale 1ns / 1ps

module tlpt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	tlpt_req_if.sink             req,
	tlpt_rsp_if.source           rsp,
	tlpt_cfg_if.sink             cfg,
	output tlpt_pkg::dir_req_t   dir_req,
	input  tlpt_pkg::dir_entry_t dir_rdata,
	output tlpt_pkg::tbl_req_t   tbl_req,
	input  logic [31:0]          tbl_rdata
);
	import tlpt_pkg::*;

	typedef enum logic [6:0] {
		ST_INIT = 7'b0000001,
		ST_IDLE = 7'b0000010,
		ST_DIR  = 7'b0000100,
		ST_CLR  = 7'b0001000,
		ST_WR   = 7'b0010000,
		ST_TRD  = 7'b0100000,
		ST_RESP = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [DIR_IDX_W-1:0] dir_idx_q;
	logic [TBL_IDX_W-1:0] tbl_idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CFG_W-1:0]     limit_q;
	logic                 out_valid_q;

	logic [1:0]        op_q;
	logic [31:0]       va_q;
	logic [31:0]       pa_q;
	logic [11:0]       flags_q;
	logic [SLOT_W-1:0] slot_q;
	logic              res_status_q;
	logic              res_mapped_q;
	logic [31:0]       res_phys_q;
	logic              out_status_q;
	logic              out_mapped_q;
	logic [31:0]       out_phys_q;

	logic [DIR_IDX_W-1:0] di;
	logic [TBL_IDX_W-1:0] ti;
	logic [LIM_W-1:0]     lim_ext;
	logic [LIM_W-1:0]     lim_eff;
	logic                 can_alloc;
	logic [SLOT_W-1:0]    new_slot;
	logic [31:0]          pte;
	logic                 alloc;
	logic                 out_free;
	logic                 accept;

	assign di       = va_q[31:22];
	assign ti       = va_q[21:12];
	assign lim_ext  = LIM_W'(limit_q);
	assign lim_eff  = (lim_ext < LIM_W'(TABLE_SLOTS)) ? lim_ext : LIM_W'(TABLE_SLOTS);
	assign can_alloc = LIM_W'(cnt_q) < lim_eff;
	assign new_slot = SLOT_W'(cnt_q);
	assign pte      = (pa_q & FRAME_MASK) | {20'b0, flags_q};
	assign alloc    = (op_q == OP_MAP) && !dir_rdata.present && can_alloc;
	assign out_free = !out_valid_q || rsp.ready;
	assign accept   = req.valid && req.ready;

	assign req.ready       = (state_q == ST_IDLE);
	assign cfg.ready       = 1'b1;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.is_mapped   = out_mapped_q;
	assign rsp.phys_result = out_phys_q;

	always_comb begin
		dir_req       = '0;
		dir_req.addr  = dir_idx_q;
		tbl_req       = '0;
		tbl_req.addr  = {slot_q, tbl_idx_q};
		case (state_q)
			ST_INIT: begin
				dir_req.en = 1'b1;
				dir_req.we = 1'b1;
			end
			ST_IDLE: begin
				dir_req.en   = req.valid;
				dir_req.addr = req.virt_addr[31:22];
			end
			ST_DIR: begin
				if (alloc) begin
					dir_req.en    = 1'b1;
					dir_req.we    = 1'b1;
					dir_req.addr  = di;
					dir_req.wdata = '{present: 1'b1, flags: flags_q, slot: new_slot};
				end
				tbl_req.addr = {dir_rdata.slot, ti};
				if (dir_rdata.present) begin
					case (op_q)
						OP_MAP: begin
							tbl_req.en    = 1'b1;
							tbl_req.we    = 1'b1;
							tbl_req.wdata = pte;
						end
						OP_UNMAP: begin
							tbl_req.en = 1'b1;
							tbl_req.we = 1'b1;
						end
						OP_QUERY: begin
							tbl_req.en = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_CLR: begin
				tbl_req.en = 1'b1;
				tbl_req.we = 1'b1;
			end
			ST_WR: begin
				tbl_req.en    = 1'b1;
				tbl_req.we    = 1'b1;
				tbl_req.addr  = {slot_q, ti};
				tbl_req.wdata = pte;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			dir_idx_q   <= '0;
			tbl_idx_q   <= '0;
			cnt_q       <= '0;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.table_slot_limit;
			end
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					dir_idx_q <= dir_idx_q + 1'b1;
					if (dir_idx_q == DIR_IDX_W'(DIR_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIR;
					end
				end
				ST_DIR: begin
					if (alloc) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_CLR;
					end else if (op_q == OP_QUERY && dir_rdata.present) begin
						state_q <= ST_TRD;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_CLR: begin
					tbl_idx_q <= tbl_idx_q + 1'b1;
					if (tbl_idx_q == TBL_IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					state_q <= ST_RESP;
				end
				ST_TRD: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			va_q    <= req.virt_addr;
			pa_q    <= req.phys_addr;
			flags_q <= req.entry_flags | FLAG_PRESENT;
		end
		if (state_q == ST_DIR) begin
			slot_q       <= new_slot;
			res_status_q <= (op_q == OP_MAP) && !dir_rdata.present && !can_alloc;
			res_mapped_q <= 1'b0;
			res_phys_q   <= '0;
		end
		if (state_q == ST_TRD && tbl_rdata[0]) begin
			res_mapped_q <= 1'b1;
			res_phys_q   <= (tbl_rdata & FRAME_MASK) | {20'b0, va_q[11:0]};
		end
		if (state_q == ST_RESP && out_free) begin
			out_status_q <= res_status_q;
			out_mapped_q <= res_mapped_q;
			out_phys_q   <= res_phys_q;
		end
	end

endmodule

// ===== tb/tb_two_level_page_table_engine.sv =====
`timescale 1ns / 1ps

module tb_two_level_page_table_engine;
	import tlpt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] va;
		logic [31:0] pa;
		logic [11:0] flags;
	} walk_req_t;

	typedef struct packed {
		logic        status;
		logic        mapped;
		logic [31:0] pa_out;
	} walk_rsp_t;

	typedef struct {
		bit         is_cfg;
		logic [3:0] limit;
		walk_req_t  req;
		bit         fixed;
		walk_rsp_t  rsp;
	} stim_row_t;

	logic clk;
	logic arst_n;

	tlpt_req_if req_ch();
	tlpt_rsp_if rsp_ch();
	tlpt_cfg_if cfg_ch();

	two_level_page_table_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// shadow page table
	logic              dir_valid     [DIR_ENTRIES];
	logic [11:0]       dir_flag_bits [DIR_ENTRIES];
	int                dir_slot_no   [DIR_ENTRIES];
	logic [31:0]       pte_store     [TABLE_SLOTS][TABLE_ENTRIES];
	int                slots_used;
	logic [3:0]        slot_limit;

	walk_rsp_t         pending_walks[$];
	stim_row_t         stim_rows[$];
	int                hot_dirs[12];
	int                hot_tidx[16];

	int n_items, n_results, n_mismatch, n_map_fail, n_hits, n_cfg;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic walk_rsp_t walk_predict(walk_req_t r);
		logic [9:0]  di;
		logic [9:0]  ti;
		logic [11:0] fl;
		logic [31:0] pte;
		int          lim;
		walk_rsp_t   o;
		di  = r.va[31:22];
		ti  = r.va[21:12];
		fl  = r.flags | FLAG_PRESENT;
		lim = (slot_limit < TABLE_SLOTS) ? int'(slot_limit) : TABLE_SLOTS;
		o   = '0;
		case (r.op)
			OP_MAP: begin
				if (!dir_valid[di]) begin
					if (slots_used < lim) begin
						for (int i = 0; i < TABLE_ENTRIES; i++)
							pte_store[slots_used][i] = '0;
						dir_valid[di]     = 1'b1;
						dir_flag_bits[di] = fl;
						dir_slot_no[di]   = slots_used;
						slots_used++;
					end else begin
						o.status = 1'b1;
					end
				end
				if (!o.status)
					pte_store[dir_slot_no[di]][ti] = (r.pa & FRAME_MASK) | {20'd0, fl};
			end
			OP_UNMAP: begin
				if (dir_valid[di])
					pte_store[dir_slot_no[di]][ti] = '0;
			end
			OP_QUERY: begin
				if (dir_valid[di]) begin
					pte = pte_store[dir_slot_no[di]][ti];
					if (pte[0]) begin
						o.mapped = 1'b1;
						o.pa_out = (pte & FRAME_MASK) | {20'd0, r.va[11:0]};
					end
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic walk_req_t rand_walk();
		walk_req_t r;
		int        sel;
		sel = $urandom_range(0, 99);
		if (sel < 35)
			r.op = OP_MAP;
		else if (sel < 50)
			r.op = OP_UNMAP;
		else if (sel < 95)
			r.op = OP_QUERY;
		else
			r.op = OP_UNUSED;
		r.va = $urandom;
		if ($urandom_range(0, 19) != 0) begin
			if ($urandom_range(0, 99) < 85)
				r.va[31:22] = 10'(hot_dirs[$urandom_range(0, 11)]);
			if ($urandom_range(0, 99) < 70)
				r.va[21:12] = 10'(hot_tidx[$urandom_range(0, 15)]);
		end
		r.pa    = $urandom;
		r.flags = 12'($urandom_range(0, 4095));
		return r;
	endfunction

	task automatic send_walk(walk_req_t r, bit fixed, walk_rsp_t fx);
		walk_rsp_t p;
		req_ch.valid       <= 1'b1;
		req_ch.operation   <= r.op;
		req_ch.virt_addr   <= r.va;
		req_ch.phys_addr   <= r.pa;
		req_ch.entry_flags <= r.flags;
		do @(posedge clk); while (!req_ch.ready);
		p = walk_predict(r);
		pending_walks.push_back(fixed ? fx : p);
		n_items++;
		if (r.op == OP_MAP && p.status)
			n_map_fail++;
		if (p.mapped)
			n_hits++;
	endtask

	// only while the engine is idle
	task automatic write_limit(logic [3:0] v);
		req_ch.valid <= 1'b0;
		while (pending_walks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_ch.valid            <= 1'b1;
		cfg_ch.table_slot_limit <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		slot_limit = v;
		n_cfg++;
	endtask

	task automatic run_random(int n_target);
		int        sent;
		int        burst;
		int        gap;
		walk_req_t r;
		sent = 0;
		while (sent < n_target) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst && sent < n_target; k++) begin
				r = rand_walk();
				send_walk(r, 1'b0, '0);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic void add_cfg(logic [3:0] v);
		stim_row_t s;
		s        = '{default: '0};
		s.is_cfg = 1'b1;
		s.limit  = v;
		stim_rows.push_back(s);
	endfunction

	function automatic void add_op(logic [1:0] op, logic [31:0] va, logic [31:0] pa,
			logic [11:0] fl);
		stim_row_t s;
		s     = '{default: '0};
		s.req = '{op, va, pa, fl};
		stim_rows.push_back(s);
	endfunction

	function automatic void add_fixed(logic [1:0] op, logic [31:0] va, logic [31:0] pa,
			logic [11:0] fl, logic st, logic mp, logic [31:0] res);
		stim_row_t s;
		s       = '{default: '0};
		s.req   = '{op, va, pa, fl};
		s.fixed = 1'b1;
		s.rsp   = '{st, mp, res};
		stim_rows.push_back(s);
	endfunction

	// result checker
	always @(posedge clk) begin
		walk_rsp_t got;
		walk_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = {rsp_ch.status, rsp_ch.is_mapped, rsp_ch.phys_result};
			n_results++;
			if (pending_walks.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("%0t: unexpected result status=%0b mapped=%0b pa=%08h",
						$realtime, got.status, got.mapped, got.pa_out);
			end else begin
				want = pending_walks.pop_front();
				if (got.status !== want.status || got.mapped !== want.mapped ||
						got.pa_out !== want.pa_out) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("%0t: result %0d exp st=%0b mp=%0b pa=%08h got st=%0b mp=%0b pa=%08h",
							$realtime, n_results, want.status, want.mapped, want.pa_out,
							got.status, got.mapped, got.pa_out);
				end
			end
		end
	end

	// result side backpressure, one long hold-off to fill the engine
	initial begin
		int  mode;
		int  cyc;
		bit  held;
		mode = 0;
		cyc  = 0;
		held = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (!held && n_results >= 300) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			case (mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				2: rsp_ch.ready <= (cyc % 4 == 0);
				default: rsp_ch.ready <= ($urandom_range(0, 99) < 85);
			endcase
		end
	end

	initial begin
		stim_row_t row;
		for (int i = 0; i < DIR_ENTRIES; i++) begin
			dir_valid[i]     = 1'b0;
			dir_flag_bits[i] = '0;
			dir_slot_no[i]   = 0;
		end
		slots_used = 0;
		slot_limit = LIMIT_RESET;
		n_items    = 0;
		n_results  = 0;
		n_mismatch = 0;
		n_map_fail = 0;
		n_hits     = 0;
		n_cfg      = 0;

		hot_dirs[0] = 0;
		hot_dirs[1] = 1023;
		hot_dirs[2] = 512;
		for (int i = 3; i < 12; i++)
			hot_dirs[i] = $urandom_range(0, 1023);
		hot_tidx[0] = 0;
		hot_tidx[1] = 1023;
		for (int i = 2; i < 16; i++)
			hot_tidx[i] = $urandom_range(0, 1023);

		arst_n                  <= 1'b0;
		req_ch.valid            <= 1'b0;
		req_ch.operation        <= OP_QUERY;
		req_ch.virt_addr        <= '0;
		req_ch.phys_addr        <= '0;
		req_ch.entry_flags      <= '0;
		cfg_ch.valid            <= 1'b0;
		cfg_ch.table_slot_limit <= '0;

		// empty pool: everything misses, map fails
		add_cfg(4'd0);
		add_fixed(OP_QUERY,  32'h0000_0000, 32'h0,         12'h000, 1'b0, 1'b0, 32'h0);
		add_fixed(OP_MAP,    32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 1'b0, 32'h0);
		add_fixed(OP_UNMAP,  32'h0000_0000, 32'h0,         12'h000, 1'b0, 1'b0, 32'h0);
		add_fixed(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1'b0, 1'b0, 32'h0);
		// two slots, then exhaustion
		add_cfg(4'd2);
		add_fixed(OP_MAP,    32'h0000_0ABC, 32'hFFFF_F123, 12'h000, 1'b0, 1'b0, 32'h0);
		add_fixed(OP_QUERY,  32'h0000_0ABC, 32'h0,         12'h000, 1'b0, 1'b1, 32'hFFFF_FABC);
		add_fixed(OP_MAP,    32'hFFFF_FFFF, 32'h0000_0FFF, 12'hFFE, 1'b0, 1'b0, 32'h0);
		add_fixed(OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1'b0, 1'b1, 32'h0000_0FFF);
		add_fixed(OP_MAP,    32'h8000_0000, 32'h1234_5000, 12'h002, 1'b1, 1'b0, 32'h0);
		add_fixed(OP_QUERY,  32'h8000_0000, 32'h0,         12'h000, 1'b0, 1'b0, 32'h0);
		add_op(OP_MAP,       32'h003F_F000, 32'hABCD_E000, 12'h0F0);
		add_op(OP_QUERY,     32'h003F_F7FF, 32'h0,         12'h000);
		add_fixed(OP_QUERY,  32'h0000_1000, 32'h0,         12'h000, 1'b0, 1'b0, 32'h0);
		add_op(OP_UNMAP,     32'h0000_0000, 32'h0,         12'h000);
		add_fixed(OP_QUERY,  32'h0000_0123, 32'h0,         12'h000, 1'b0, 1'b0, 32'h0);
		add_fixed(OP_UNMAP,  32'h0040_0000, 32'h0,         12'h000, 1'b0, 1'b0, 32'h0);
		add_op(OP_MAP,       32'h0000_0000, 32'h0,         12'h000);
		add_op(OP_QUERY,     32'h0000_0FFF, 32'h0,         12'h000);
		// limit above pool size
		add_cfg(4'd15);
		add_op(OP_MAP,       32'h8000_0000, 32'h5A5A_5000, 12'hAAA);
		add_op(OP_QUERY,     32'h8000_0555, 32'h0,         12'h555);
		add_op(OP_UNUSED,    32'h0000_0000, 32'h0,         12'h000);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.is_cfg)
				write_limit(row.limit);
			else
				send_walk(row.req, row.fixed, row.rsp);
		end

		run_random(900);
		write_limit(4'd1);
		run_random(450);
		write_limit(4'd8);
		run_random(450);

		req_ch.valid <= 1'b0;
		while (pending_walks.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("run: %0d items, %0d results, %0d limit writes, %0d tables allocated",
			n_items, n_results, n_cfg, slots_used);
		$display("     %0d maps refused for lack of slots, %0d query hits, %0d mismatches",
			n_map_fail, n_hits, n_mismatch);
		if (n_mismatch == 0 && pending_walks.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
design/tlpt_pkg.sv
design/tlpt_if.sv
design/tlpt_dir_ram.sv
design/tlpt_tbl_ram.sv
design/tlpt_ctrl.sv
design/two_level_page_table_engine.sv
tb/tb_two_level_page_table_engine.sv
